>>> design/assert_macros.svh
// Assertion macros shared by the parser RTL; clocked on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define SRFP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define SRFP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/srfp_pkg.sv
// Types, constants and word tables for the sensor record field parser.
package srfp_pkg;

  typedef enum logic [1:0] {
    PH_BLANK,
    PH_SIGN,
    PH_DIGITS,
    PH_STOP
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_DIGITS  = 3'd1,
    ST_BAD_MOVE   = 3'd2,
    ST_BAD_LIGHT  = 3'd3,
    ST_FEW_FIELDS = 3'd4,
    ST_RANGE      = 3'd5
  } status_e;

  // Field positions within a record
  localparam logic [2:0] FLD_TEMP_OUT = 3'd0;
  localparam logic [2:0] FLD_TEMP_IN  = 3'd1;
  localparam logic [2:0] FLD_MOVE     = 3'd2;
  localparam logic [2:0] FLD_LIGHT    = 3'd3;
  localparam logic [2:0] FLD_DONE     = 3'd4;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Magnitude limits
  localparam logic [32:0] ACC_LIMIT = 33'h0_8000_0000;
  localparam logic [32:0] ACC_CLAMP = 33'h0_8000_0001;
  localparam logic [32:0] POS_MAX   = 33'h0_7FFF_FFFF;

  // Staged input byte
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
    logic       eor;
  } stage_t;

  // Per-field scan state
  typedef struct packed {
    phase_e      phase;
    logic [32:0] acc;
    logic        neg;
    logic [1:0]  wcnt;
    logic [1:0]  wdead;
  } fld_t;

  // Per-record state
  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] temp_out;
    logic [31:0] temp_in;
    logic [1:0]  flags;
    status_e     err;
  } rec_t;

  // One result transaction
  typedef struct packed {
    logic [31:0] outside_temp;
    logic [31:0] inside_temp;
    logic        movement_seen;
    logic        light_is_on;
    status_e     status;
  } result_t;

  localparam fld_t FLD_CLEAR = '{PH_BLANK, 33'd0, 1'b0, 2'd0, 2'd0};
  localparam rec_t REC_CLEAR = '{FLD_TEMP_OUT, 32'd0, 32'd0, 2'd0, ST_OK};

  // Accepting word ("yes" for movement, "on" for light): {valid, char}
  function automatic logic [8:0] true_char(logic kind, logic [1:0] pos);
    logic [8:0] r;
    r = 9'd0;
    unique case ({kind, pos})
      3'b000:  r = {1'b1, 8'h79};
      3'b001:  r = {1'b1, 8'h65};
      3'b010:  r = {1'b1, 8'h73};
      3'b100:  r = {1'b1, 8'h6F};
      3'b101:  r = {1'b1, 8'h6E};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Rejecting word ("no" for movement, "off" for light): {valid, char}
  function automatic logic [8:0] false_char(logic kind, logic [1:0] pos);
    logic [8:0] r;
    r = 9'd0;
    unique case ({kind, pos})
      3'b000:  r = {1'b1, 8'h6E};
      3'b001:  r = {1'b1, 8'h6F};
      3'b100:  r = {1'b1, 8'h6F};
      3'b101:  r = {1'b1, 8'h66};
      3'b110:  r = {1'b1, 8'h66};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] true_len(logic kind);
    return kind ? 2'd2 : 2'd3;
  endfunction

  function automatic logic [1:0] false_len(logic kind);
    return kind ? 2'd3 : 2'd2;
  endfunction

endpackage

>>> design/srfp_in_if.sv
// Byte input channel: one text byte and its end-of-record flag per transaction.
interface srfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_record;

  modport source (output valid, output char_in, output end_of_record, input ready);
  modport sink (input valid, input char_in, input end_of_record, output ready);
endinterface

>>> design/srfp_out_if.sv
// Result channel: parsed record values and status per transaction.
interface srfp_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] outside_temp;
  logic signed [31:0] inside_temp;
  logic              movement_seen;
  logic              light_is_on;
  logic [2:0]        status;

  modport source (
    output valid, output outside_temp, output inside_temp,
    output movement_seen, output light_is_on, output status, input ready
  );
  modport sink (
    input valid, input outside_temp, input inside_temp,
    input movement_seen, input light_is_on, input status, output ready
  );
endinterface

>>> design/srfp_in_stage.sv
// Input register: holds one accepted byte until the parser core consumes it.
module srfp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  srfp_in_if.sink         byte_i,
  input  logic            advance_i,
  output srfp_pkg::stage_t stage_o
);
  import srfp_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] ch_q;
  logic       eor_q;
  logic       accept;

  // Free slot, or slot drains this cycle
  assign byte_i.ready = !valid_q || advance_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q  <= byte_i.char_in;
      eor_q <= byte_i.end_of_record;
    end
  end

  assign stage_o = '{valid: valid_q, ch: ch_q, eor: eor_q};
endmodule

>>> design/srfp_core.sv
// Parser core: field split, number scan, word match and record result per byte.
`include "assert_macros.svh"
module srfp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  input  srfp_pkg::stage_t  stage_i,
  input  logic              can_load_i,
  output logic              advance_o,
  output logic              res_valid_o,
  output srfp_pkg::result_t res_o
);
  import srfp_pkg::*;

  logic [7:0] delim_q;
  fld_t       fld_q, fld_d, fld_a;
  rec_t       rec_q, rec_d, rec_a, rec_b;
  logic       delim_hit;
  status_e    st;

  function automatic rec_t note_err(rec_t r, status_e code);
    rec_t o;
    o = r;
    if (o.err == ST_OK) begin
      o.err = code;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Byte ends the numeric scan without any digit seen
  function automatic logic num_bad(fld_t f, logic [7:0] c);
    logic skip, sgn, dig;
    skip = (f.phase == PH_BLANK) && is_blank(c);
    sgn  = (f.phase == PH_BLANK) && ((c == CH_PLUS) || (c == CH_MINUS));
    dig  = (f.phase != PH_STOP) && is_digit(c);
    return !skip && !sgn && !dig && ((f.phase == PH_BLANK) || (f.phase == PH_SIGN));
  endfunction

  // strtol-style scan of one byte; magnitude clamps just above 2^31
  function automatic fld_t num_step(fld_t f, logic [7:0] c);
    fld_t        o;
    logic [35:0] prod;
    o = f;
    prod = {f.acc, 3'b000} + {2'b00, f.acc, 1'b0} + {32'd0, c[3:0] - CH_ZERO[3:0]};
    if ((f.phase == PH_BLANK) && is_blank(c)) begin
      o = f;
    end else if ((f.phase == PH_BLANK) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
      o.neg   = (c == CH_MINUS);
      o.phase = PH_SIGN;
    end else if ((f.phase != PH_STOP) && is_digit(c)) begin
      o.phase = PH_DIGITS;
      if (f.acc <= ACC_LIMIT) begin
        o.acc = (prod > {3'b000, ACC_LIMIT}) ? ACC_CLAMP : prod[32:0];
      end
    end else begin
      o.phase = PH_STOP;
    end
    return o;
  endfunction

  // Exact-match tracking against the two candidate words
  function automatic fld_t word_step(fld_t f, logic [7:0] c, logic kind);
    fld_t       o;
    logic [8:0] tc, fc;
    o  = f;
    tc = true_char(kind, f.wcnt);
    fc = false_char(kind, f.wcnt);
    if (f.wcnt == 2'd3) begin
      o.wdead = 2'b11;
    end else begin
      if (!tc[8] || (tc[7:0] != c)) begin
        o.wdead[0] = 1'b1;
      end
      if (!fc[8] || (fc[7:0] != c)) begin
        o.wdead[1] = 1'b1;
      end
      o.wcnt = f.wcnt + 2'd1;
    end
    return o;
  endfunction

  // Close the current field and move on to the next one
  function automatic rec_t finish(rec_t r, fld_t f);
    rec_t        o;
    logic        over;
    logic [31:0] v;
    logic        kind;
    o    = r;
    kind = r.idx[0];
    over = f.neg ? (f.acc > ACC_LIMIT) : (f.acc > POS_MAX);
    v    = f.neg ? (32'd0 - f.acc[31:0]) : f.acc[31:0];
    if (r.idx < FLD_MOVE) begin
      if ((f.phase == PH_BLANK) || (f.phase == PH_SIGN)) begin
        o = note_err(o, ST_NO_DIGITS);
      end else begin
        if (over) begin
          o = note_err(o, ST_RANGE);
        end
        if (r.idx == FLD_TEMP_OUT) begin
          o.temp_out = v;
        end else begin
          o.temp_in = v;
        end
      end
    end else if (r.idx < FLD_DONE) begin
      if (!f.wdead[0] && (f.wcnt == true_len(kind))) begin
        o.flags[kind] = 1'b1;
      end else if (!f.wdead[1] && (f.wcnt == false_len(kind))) begin
        o.flags[kind] = 1'b0;
      end else begin
        o = note_err(o, kind ? ST_BAD_LIGHT : ST_BAD_MOVE);
      end
    end
    if (r.idx < FLD_DONE) begin
      o.idx = r.idx + 3'd1;
    end
    return o;
  endfunction

  // Delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DELIM_RESET;
    end else if (cfg_we_i) begin
      delim_q <= cfg_data_i;
    end
  end

  // Byte may proceed unless it ends a record and the result slot is busy
  assign advance_o   = stage_i.valid && (!stage_i.eor || can_load_i);
  assign res_valid_o = advance_o && stage_i.eor;
  assign delim_hit   = (stage_i.ch == delim_q);

  // Per-byte update
  always_comb begin
    rec_a = rec_q;
    fld_a = fld_q;
    if (delim_hit) begin
      rec_a = finish(rec_q, fld_q);
      fld_a = FLD_CLEAR;
    end else if (rec_q.idx < FLD_MOVE) begin
      fld_a = num_step(fld_q, stage_i.ch);
      if (num_bad(fld_q, stage_i.ch)) begin
        rec_a = note_err(rec_q, ST_NO_DIGITS);
      end
    end else if (rec_q.idx < FLD_DONE) begin
      fld_a = word_step(fld_q, stage_i.ch, rec_q.idx[0]);
    end
  end

  // End of record: close the open field, then form the status
  always_comb begin
    rec_b = (rec_a.idx < FLD_DONE) ? finish(rec_a, fld_a) : rec_a;
    st    = rec_b.err;
    if ((st == ST_OK) && (rec_b.idx < FLD_DONE)) begin
      st = ST_FEW_FIELDS;
    end
    res_o = '{32'd0, 32'd0, 1'b0, 1'b0, st};
    if (st == ST_OK) begin
      res_o = '{rec_b.temp_out, rec_b.temp_in, rec_b.flags[0], rec_b.flags[1], ST_OK};
    end
  end

  // Next state
  always_comb begin
    rec_d = rec_q;
    fld_d = fld_q;
    if (advance_o) begin
      if (stage_i.eor) begin
        rec_d = REC_CLEAR;
        fld_d = FLD_CLEAR;
      end else begin
        rec_d = rec_a;
        fld_d = fld_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= REC_CLEAR;
      fld_q <= FLD_CLEAR;
    end else begin
      rec_q <= rec_d;
      fld_q <= fld_d;
    end
  end

  `SRFP_ASSERT_NXT(a_clear_after_result, res_valid_o,
    (rec_q.idx == FLD_TEMP_OUT) && (rec_q.err == ST_OK) && (fld_q.phase == PH_BLANK),
    "record state not cleared after a result")
  `SRFP_ASSERT_IMP(a_scan_only_numeric, fld_q.phase != PH_BLANK,
    rec_q.idx < FLD_MOVE, "number scan active outside a numeric field")
endmodule

>>> design/srfp_out_stage.sv
// Result register: holds one record result until the receiver takes it.
`include "assert_macros.svh"
module srfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  srfp_pkg::result_t res_i,
  output logic              can_load_o,
  srfp_out_if.source        result_o
);
  import srfp_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign can_load_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.outside_temp  = data_q.outside_temp;
  assign result_o.inside_temp   = data_q.inside_temp;
  assign result_o.movement_seen = data_q.movement_seen;
  assign result_o.light_is_on   = data_q.light_is_on;
  assign result_o.status        = data_q.status;

  `SRFP_ASSERT_IMP(a_error_zeroes_values, valid_q && (data_q.status != ST_OK),
    (data_q.outside_temp == 32'd0) && (data_q.inside_temp == 32'd0) &&
    !data_q.movement_seen && !data_q.light_is_on,
    "error result carries nonzero values")
endmodule

>>> design/sensor_record_field_parser.sv
// Sensor record field parser: text bytes in, one parsed record result per record out.
//
// byte_i carries one text byte (char_in) per transaction; end_of_record marks
// the last byte of a record. The record splits at the delimiter byte into
// outside temperature, inside temperature, movement word and light word.
// result_o carries one transaction per record: the four values and a status.
// cfg_we_i/cfg_data_i write the delimiter; write it only while the block is idle.
//
// Throughput: one byte per cycle, unless a full result register stalls the input.
// Each byte passes an input register, then the parse logic (multiply-by-ten
// accumulate and word compare) updates the record state and, on the last byte,
// loads the result register, whose valid bit drives result_o.valid.
// Reset clears both registers' valid bits, the record state, and sets the
// delimiter to a comma. When the receiver stalls, bytes keep flowing until
// the next end-of-record byte reaches a full result register; that byte then
// waits in the input register and byte_i.ready drops until the result drains.
module sensor_record_field_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  srfp_in_if.sink    byte_i,
  srfp_out_if.source result_o
);
  import srfp_pkg::*;

  stage_t  stage;
  result_t res;
  logic    advance;
  logic    res_valid;
  logic    can_load;

  srfp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .byte_i    (byte_i),
    .advance_i (advance),
    .stage_o   (stage)
  );

  srfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .stage_i     (stage),
    .can_load_i  (can_load),
    .advance_o   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  srfp_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .can_load_o (can_load),
    .result_o   (result_o)
  );
endmodule
